### rtl/fbs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fbs_pkg - shared types and codes of the fault batch sorter
// Input selector codes, result status codes, back-end states, command and result records.
// ============================================================================
package fbs_pkg;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_WAIT  = 2'd1;
    localparam logic [1:0] FUNC_DRAIN = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_NOSLOT = 2'd3;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_WAIT,
        OP_DRAIN
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] page;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RING_RD,
        S_INS_RD,
        S_INS_CMP,
        S_FINISH,
        S_OUT_RD,
        S_OUT_LD
    } back_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        last;
        logic [31:0] page;
        logic [31:0] seq;
        logic [7:0]  slot;
        logic [8:0]  woken;
        logic [63:0] batches;
        logic [63:0] pages;
        logic [6:0]  largest;
        logic [63:0] wakeups;
    } result_t;

endpackage

### rtl/fault_batch_sorter_top.sv
`timescale 1ns / 1ps
// ============================================================================
// fault_batch_sorter_top - fault page ring with sorted batch drain
// Collects faulting pages, hands out waiter slots and drains sorted batches.
// ============================================================================
// Each input item carries a selector in s_axis_tuser: 0 pushes the page in
// s_axis_tdata into a ring of RING_SIZE entries and returns its sequence
// number (status 1 when the ring is full), 1 registers a waiter in the lowest
// free slot (status 3 when all MAX_WAITERS slots are busy), 2 drains the ring:
// the pages come out ascending, one item each, tlast on the final one, every
// one carrying the updated batch, page, peak and wake-up totals; all waiter
// slots are freed and counted. An empty drain returns status 2; selector 3
// gives no result. Items pass a two-entry command queue into the executing
// engine, so up to two items are taken while the engine works. A push or a
// registration passes the queue entry and then the output register, and the
// engine takes one each cycle while the output drains. A drain of n pages
// is an insertion sort over one single-ported batch memory with registered
// read: each page is read from the ring, each larger entry below it is read
// and moved up one position, and the page is written where it stops above
// a smaller or equal page or at the front. The totals are then updated and
// each page loaded into the output register. No clearing pass after reset.
// ============================================================================
module fault_batch_sorter_top
    import fbs_pkg::*;
#(
    parameter int RING_SIZE   = 64,
    parameter int MAX_WAITERS = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // fault page
    input  logic [1:0]   s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // page_out, seq_out, waiter_slot, woken_count, batches_done, pages_done,
    // largest_batch, wakeups_done
    output logic [279:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // status
    output logic         m_axis_tlast
);

    localparam int CW = $clog2(RING_SIZE + 1);
    localparam int WW = $clog2(MAX_WAITERS + 1);

    logic          cmd_valid, cmd_ready;
    cmd_t          cmd;
    result_t       res;
    logic [CW-1:0] fill_level;
    logic [WW-1:0] waiter_level;

    // decode and queue
    fbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_page   (s_axis_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // ring, waiters, sort engine and output register
    fbs_back #(
        .RING_SIZE   (RING_SIZE),
        .MAX_WAITERS (MAX_WAITERS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .res_valid    (m_axis_tvalid),
        .res_ready    (m_axis_tready),
        .res          (res),
        .fill_level   (fill_level),
        .waiter_level (waiter_level)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {res.wakeups, res.largest, res.pages, res.batches,
                           res.woken, res.slot, res.seq, res.page};

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_level <= CW'(RING_SIZE))
        else $error("ring fill beyond capacity");

    a_waiter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        waiter_level <= WW'(MAX_WAITERS))
        else $error("waiter count beyond capacity");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast)
        else $error("error result without last mark");
`endif

endmodule

### rtl/fbs_front.sv
`timescale 1ns / 1ps
// ============================================================================
// fbs_front - input decode and command queue
// Classifies each item by its selector and queues it for the back end.
// ============================================================================
module fbs_front
    import fbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_func,
    input  logic [31:0] in_page,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       head_reg, head_next;
    logic       keep;
    logic       enq, deq;
    cmd_t       dec;

    // selector 3 is taken and dropped
    always_comb
    begin
        keep     = 1'b1;
        dec.page = in_page;
        dec.op   = OP_PUSH;
        case (in_func)
            FUNC_PUSH:  dec.op = OP_PUSH;
            FUNC_WAIT:  dec.op = OP_WAIT;
            FUNC_DRAIN: dec.op = OP_DRAIN;
            default:    keep   = 1'b0;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[head_reg];
    assign enq       = in_valid && in_ready && keep;
    assign deq       = cmd_valid && cmd_ready;

    always_comb
    begin
        cnt_next  = cnt_reg + 2'(enq) - 2'(deq);
        head_next = deq ? ~head_reg : head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[head_reg ^ (cnt_reg != 2'd0 && !(deq && cnt_reg == 2'd1) ? 1'b1 : 1'b0)
                  ^ (deq && cnt_reg == 2'd1 ? 1'b1 : 1'b0)] <= dec;
        end
    end

endmodule

### rtl/fbs_back.sv
`timescale 1ns / 1ps
// ============================================================================
// fbs_back - ring, waiter count and batch insertion sort
// Executes queued commands and produces the result items.
// ============================================================================
module fbs_back
    import fbs_pkg::*;
#(
    parameter int RING_SIZE   = 64,
    parameter int MAX_WAITERS = 256
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  cmd_t                               cmd,
    output logic                               res_valid,
    input  logic                               res_ready,
    output result_t                            res,
    output logic [$clog2(RING_SIZE+1)-1:0]     fill_level,
    output logic [$clog2(MAX_WAITERS+1)-1:0]   waiter_level
);

    localparam int AW = $clog2(RING_SIZE);
    localparam int CW = $clog2(RING_SIZE + 1);
    localparam int WW = $clog2(MAX_WAITERS + 1);

    logic [31:0] ring_mem [RING_SIZE];
    logic [31:0] bmem     [RING_SIZE];

    back_state_t state_reg, state_next;

    logic [AW-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [31:0]   seq_reg, seq_next;
    logic [WW-1:0] wcnt_reg, wcnt_next, woken_reg, woken_next;
    logic [63:0]   btot_reg, btot_next, ptot_reg, ptot_next, wtot_reg, wtot_next;
    logic [CW-1:0] peak_reg, peak_next;
    logic [CW-1:0] n_reg, n_next, i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [31:0]   ring_rd_reg, bmem_rd_reg;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic          out_free;
    logic          ring_we, ring_re, bmem_we, bmem_re;
    logic [AW-1:0] bmem_waddr, bmem_raddr;
    logic [31:0]   bmem_wdata;
    logic          ins_done;

    function automatic logic [AW-1:0] step_ptr(input logic [AW-1:0] p);
        step_ptr = (p == AW'(RING_SIZE - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free     = !out_valid_reg || res_ready;
    assign cmd_ready    = (state_reg == S_IDLE) && out_free;
    assign res_valid    = out_valid_reg;
    assign res          = out_reg;
    assign fill_level   = fill_reg;
    assign waiter_level = wcnt_reg;
    assign ins_done     = (i_reg + 1'b1 == n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free && cmd.op == OP_DRAIN && fill_reg != '0)
                    state_next = S_RING_RD;
            end
            S_RING_RD: state_next = S_INS_RD;
            S_INS_RD:
            begin
                if (j_reg != '0)
                    state_next = S_INS_CMP;
                else
                    state_next = ins_done ? S_FINISH : S_RING_RD;
            end
            S_INS_CMP:
            begin
                if (bmem_rd_reg > ring_rd_reg)
                    state_next = S_INS_RD;
                else
                    state_next = ins_done ? S_FINISH : S_RING_RD;
            end
            S_FINISH:  state_next = S_OUT_RD;
            S_OUT_RD:  state_next = S_OUT_LD;
            S_OUT_LD:
            begin
                if (out_free)
                    state_next = (k_reg + 1'b1 == n_reg) ? S_IDLE : S_OUT_RD;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        fill_next      = fill_reg;
        seq_next       = seq_reg;
        wcnt_next      = wcnt_reg;
        woken_next     = woken_reg;
        btot_next      = btot_reg;
        ptot_next      = ptot_reg;
        wtot_next      = wtot_reg;
        peak_next      = peak_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        bmem_we        = 1'b0;
        bmem_re        = 1'b0;
        bmem_waddr     = j_reg[AW-1:0];
        bmem_wdata     = ring_rd_reg;
        bmem_raddr     = j_reg[AW-1:0] - 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    out_next      = '0;
                    out_next.last = 1'b1;
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (fill_reg == CW'(RING_SIZE))
                                out_next.status = ST_FULL;
                            else
                            begin
                                ring_we         = 1'b1;
                                wptr_next       = step_ptr(wptr_reg);
                                fill_next       = fill_reg + 1'b1;
                                seq_next        = seq_reg + 1'b1;
                                out_next.status = ST_OK;
                                out_next.seq    = seq_reg;
                            end
                        end
                        OP_WAIT:
                        begin
                            out_valid_next = 1'b1;
                            if (wcnt_reg == WW'(MAX_WAITERS))
                                out_next.status = ST_NOSLOT;
                            else
                            begin
                                // slots only ever free all at once, so the
                                // busy slots are always 0 .. count-1
                                wcnt_next       = wcnt_reg + 1'b1;
                                out_next.status = ST_OK;
                                out_next.slot   = 8'(wcnt_reg);
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (fill_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                n_next = fill_reg;
                                i_next = '0;
                            end
                        end
                        default: out_next = out_reg;
                    endcase
                end
            end
            S_RING_RD:
            begin
                ring_re   = 1'b1;
                rptr_next = step_ptr(rptr_reg);
                fill_next = fill_reg - 1'b1;
                j_next    = i_reg;
            end
            S_INS_RD:
            begin
                if (j_reg == '0)
                begin
                    bmem_we = 1'b1;
                    i_next  = i_reg + 1'b1;
                end
                else
                    bmem_re = 1'b1;
            end
            S_INS_CMP:
            begin
                bmem_we = 1'b1;
                if (bmem_rd_reg > ring_rd_reg)
                begin
                    bmem_wdata = bmem_rd_reg;
                    j_next     = j_reg - 1'b1;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            S_FINISH:
            begin
                btot_next  = btot_reg + 64'd1;
                ptot_next  = ptot_reg + 64'(n_reg);
                peak_next  = (n_reg > peak_reg) ? n_reg : peak_reg;
                wtot_next  = wtot_reg + 64'(wcnt_reg);
                woken_next = wcnt_reg;
                wcnt_next  = '0;
                k_next     = '0;
            end
            S_OUT_RD:
            begin
                bmem_re    = 1'b1;
                bmem_raddr = k_reg[AW-1:0];
            end
            S_OUT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_next         = '0;
                    out_next.status  = ST_OK;
                    out_next.last    = (k_reg + 1'b1 == n_reg);
                    out_next.page    = bmem_rd_reg;
                    out_next.woken   = 9'(woken_reg);
                    out_next.batches = btot_reg;
                    out_next.pages   = ptot_reg;
                    out_next.largest = 7'(peak_reg);
                    out_next.wakeups = wtot_reg;
                    k_next           = k_reg + 1'b1;
                end
            end
            default: out_next = out_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            fill_reg      <= '0;
            seq_reg       <= '0;
            wcnt_reg      <= '0;
            btot_reg      <= '0;
            ptot_reg      <= '0;
            wtot_reg      <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            fill_reg      <= fill_next;
            seq_reg       <= seq_next;
            wcnt_reg      <= wcnt_next;
            btot_reg      <= btot_next;
            ptot_reg      <= ptot_next;
            wtot_reg      <= wtot_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        woken_reg <= woken_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        out_reg   <= out_next;
    end

    // ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wptr_reg] <= cmd.page;
        if (ring_re)
            ring_rd_reg <= ring_mem[rptr_reg];
    end

    // batch memory
    always_ff @(posedge clk)
    begin
        if (bmem_we)
            bmem[bmem_waddr] <= bmem_wdata;
        if (bmem_re)
            bmem_rd_reg <= bmem[bmem_raddr];
    end

endmodule
